FILE: rtl/core/sintay_pkg.sv
package sintay_pkg;

  localparam int TAYLOR_TERMS = 6;
  localparam int COEF_MAX     = 10;
  // term count clamped to 1..COEF_MAX
  localparam int TERMS_C = (TAYLOR_TERMS < 1) ? 1 :
                           ((TAYLOR_TERMS > COEF_MAX) ? COEF_MAX : TAYLOR_TERMS);
  localparam int NCELL   = TERMS_C - 1;

  localparam logic [31:0] TWO_OVER_PI_Q32 = 32'hA2F9836E;
  localparam logic [30:0] PI_HALF_Q30     = 31'd1686629713;
  localparam logic signed [33:0] ONE_Q30  = 34'sd1073741824;

  typedef struct packed {
    logic signed [31:0] x;
    logic signed [32:0] x2;
    logic signed [31:0] p;
  } hstage_t;

  // 1/(2k+1)! in Q2.30, round to nearest
  function automatic logic signed [31:0] inv_odd_fact(input int k);
    logic signed [31:0] c;
    case (k)
      0:       c = 32'sd1073741824;
      1:       c = 32'sd178956971;
      2:       c = 32'sd8947849;
      3:       c = 32'sd213044;
      4:       c = 32'sd2959;
      5:       c = 32'sd27;
      default: c = 32'sd0;
    endcase
    return c;
  endfunction

endpackage

FILE: rtl/core/sintay_reduce.sv
module sintay_reduce import sintay_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               up_valid,
  input  logic signed [31:0] up_angle,
  output logic               up_adv,
  output logic               dn_valid,
  output hstage_t            dn_data,
  input  logic               dn_adv
);

  localparam logic [59:0] ONE_Q56   = 60'd1 << 56;
  localparam logic [59:0] TWO_Q56   = 60'd2 << 56;
  localparam logic [59:0] THREE_Q56 = 60'd3 << 56;
  localparam logic [59:0] FOUR_Q56  = 60'd4 << 56;

  logic               va_r, vb_r, vc_r, vd_r, ve_r;
  logic               adv_a, adv_b, adv_c, adv_d, adv_e;
  logic signed [31:0] angle_r;
  logic [57:0]        prod_r;
  logic signed [33:0] r32_r;
  logic signed [31:0] xd_r;
  hstage_t            data_r;

  logic signed [64:0] prod_nxt;
  logic [59:0]        m;
  logic [59:0]        r;
  logic [59:0]        r_sum;
  logic signed [65:0] xs_prod;
  logic signed [65:0] xs_sum;
  logic signed [63:0] xx_prod;
  logic signed [63:0] xx_sum;

  assign adv_e  = !ve_r || dn_adv;
  assign adv_d  = !vd_r || adv_e;
  assign adv_c  = !vc_r || adv_d;
  assign adv_b  = !vb_r || adv_c;
  assign adv_a  = !va_r || adv_b;
  assign up_adv = adv_a;

  // quarter turns, Q.56
  assign prod_nxt = angle_r * $signed({1'b0, TWO_OVER_PI_Q32});

  // fold [0,4) into [-1,1]
  always_comb begin
    m = {2'b00, prod_r};
    if (m <= ONE_Q56) begin
      r = m;
    end else if (m <= THREE_Q56) begin
      r = TWO_Q56 - m;
    end else begin
      r = m - FOUR_Q56;
    end
    r_sum = r + (60'd1 << 23);
  end

  assign xs_prod = r32_r * $signed({1'b0, PI_HALF_Q30});
  assign xs_sum  = xs_prod + (66'sd1 <<< 31);
  assign xx_prod = xd_r * xd_r;
  assign xx_sum  = xx_prod + (64'sd1 <<< 29);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0;
      vb_r <= 1'b0;
      vc_r <= 1'b0;
      vd_r <= 1'b0;
      ve_r <= 1'b0;
    end else begin
      if (adv_a) va_r <= up_valid;
      if (adv_b) vb_r <= va_r;
      if (adv_c) vc_r <= vb_r;
      if (adv_d) vd_r <= vc_r;
      if (adv_e) ve_r <= vd_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv_a) angle_r <= up_angle;
    if (adv_b) prod_r  <= prod_nxt[57:0];
    if (adv_c) r32_r   <= $signed(r_sum[57:24]);
    if (adv_d) xd_r    <= $signed(xs_sum[63:32]);
    if (adv_e) begin
      data_r.x  <= xd_r;
      data_r.x2 <= $signed(xx_sum[62:30]);
      data_r.p  <= inv_odd_fact(TERMS_C - 1);
    end
  end

  assign dn_valid = ve_r;
  assign dn_data  = data_r;

endmodule

FILE: rtl/core/sintay_cell.sv
module sintay_cell import sintay_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic signed [31:0] coef,
  input  logic               up_valid,
  input  hstage_t            up_data,
  output logic               up_adv,
  output logic               dn_valid,
  output hstage_t            dn_data,
  input  logic               dn_adv
);

  logic               valid_r;
  hstage_t            data_r;
  logic signed [64:0] prod;
  logic signed [64:0] prod_sum;
  logic signed [31:0] p_nxt;

  assign up_adv = !valid_r || dn_adv;

  // one Horner step: p = c - round(x2 * p)
  assign prod     = up_data.x2 * up_data.p;
  assign prod_sum = prod + (65'sd1 <<< 29);
  assign p_nxt    = coef - $signed(prod_sum[61:30]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (up_adv) begin
      valid_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_adv) begin
      data_r.x  <= up_data.x;
      data_r.x2 <= up_data.x2;
      data_r.p  <= p_nxt;
    end
  end

  assign dn_valid = valid_r;
  assign dn_data  = data_r;

endmodule

FILE: rtl/core/sine_taylor_range_reduced_top.sv
// Channel  Ports                          Word
// input    in_valid, in_stall, in_angle    angle, Q8.24 radians
// output   out_valid, out_stall, out_sine  sine, Q2.30, limited to +-1.0
//
// One word per cycle while out_stall is low. Stages: five range-reduction stages,
// one Horner cell per term after the first, one output stage.
// Each stage holds one word and moves on when the stage after it is empty or moving.
// Reset (rst_n low, synchronous) empties every stage; out_valid drops.
// in_stall rises only when every stage is full and out_stall is high.
module sine_taylor_range_reduced_top import sintay_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [31:0] in_angle,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] out_sine
);

  logic    cv   [0:NCELL];
  logic    cadv [0:NCELL];
  hstage_t cd   [0:NCELL];
  logic    red_adv;

  logic               out_valid_r;
  logic signed [31:0] out_sine_r;
  logic signed [63:0] y_prod;
  logic signed [63:0] y_sum;
  logic signed [33:0] y;
  logic signed [31:0] y_sat;

  sintay_reduce u_reduce (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (in_valid),
    .up_angle (in_angle),
    .up_adv   (red_adv),
    .dn_valid (cv[0]),
    .dn_data  (cd[0]),
    .dn_adv   (cadv[0])
  );

  assign in_stall = !red_adv;

  for (genvar j = 0; j < NCELL; j++) begin : g_cell
    sintay_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .coef     (inv_odd_fact(TERMS_C - 2 - j)),
      .up_valid (cv[j]),
      .up_data  (cd[j]),
      .up_adv   (cadv[j]),
      .dn_valid (cv[j+1]),
      .dn_data  (cd[j+1]),
      .dn_adv   (cadv[j+1])
    );
  end

  assign cadv[NCELL] = !out_valid_r || !out_stall;

  // final x * p, then clamp to +-1.0
  assign y_prod = cd[NCELL].x * cd[NCELL].p;
  assign y_sum  = y_prod + (64'sd1 <<< 29);
  assign y      = $signed(y_sum[63:30]);

  always_comb begin
    if (y > ONE_Q30) begin
      y_sat = ONE_Q30[31:0];
    end else if (y < -ONE_Q30) begin
      y_sat = -(ONE_Q30[31:0]);
    end else begin
      y_sat = y[31:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cadv[NCELL]) begin
      out_valid_r <= cv[NCELL];
    end
  end

  always_ff @(posedge clk) begin
    if (cadv[NCELL]) out_sine_r <= y_sat;
  end

  assign out_valid = out_valid_r;
  assign out_sine  = out_sine_r;

  a_sat_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_sine <= 32'sd1073741824 && out_sine >= -32'sd1073741824))
    else $error("sine word outside +-1.0");

  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (out_valid && out_stall))
    else $error("input stalled while output side can move");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("output valid right after reset");

endmodule

FILE: tb/sv/sine_taylor_range_reduced_checker.sv
`timescale 1ns / 1ps

module sine_taylor_range_reduced_checker import sintay_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_stall,
  input  logic signed [31:0] in_angle,
  input  logic               out_valid,
  input  logic               out_stall,
  input  logic signed [31:0] out_sine,
  output int                 fail_count,
  output int                 backlog
);

  localparam int N_TERMS = (TAYLOR_TERMS < 1) ? 1 :
                           ((TAYLOR_TERMS > 10) ? 10 : TAYLOR_TERMS);
  localparam longint QTR_TURNS_PER_RAD = 64'sd2734261102;      // 2/pi, Q0.32
  localparam longint HALF_PI_Q30       = 64'sd1686629713;
  localparam longint UNIT_Q30          = 64'sd1073741824;
  localparam longint UNIT_Q56          = 64'sh0100_0000_0000_0000;
  localparam longint MOD4_MASK         = 64'sh03FF_FFFF_FFFF_FFFF;

  // 1/(2k+1)! in Q2.30
  longint recip_odd_fact [10] = '{64'sd1073741824, 64'sd178956971, 64'sd8947849,
                                  64'sd213044, 64'sd2959, 64'sd27, 64'sd0, 64'sd0,
                                  64'sd0, 64'sd0};

  logic signed [31:0] expected_sines [$];
  int mismatches = 0;
  int sines_due  = 0;

  assign fail_count = mismatches;
  assign backlog    = sines_due;

  function automatic longint round_half_up(input longint v, input int s);
    return (v + (64'sd1 <<< (s - 1))) >>> s;
  endfunction

  function automatic logic signed [31:0] sine_of_angle(input logic signed [31:0] angle);
    longint m;
    longint r;
    longint x;
    longint x2;
    longint p;
    longint y;
    // quarter turns, folded into [0,4) by keeping the low bits
    m = (longint'(angle) * QTR_TURNS_PER_RAD) & MOD4_MASK;
    if (m <= UNIT_Q56) begin
      r = m;
    end else if (m <= 3 * UNIT_Q56) begin
      r = 2 * UNIT_Q56 - m;
    end else begin
      r = m - 4 * UNIT_Q56;
    end
    x  = round_half_up(round_half_up(r, 24) * HALF_PI_Q30, 32);
    x2 = round_half_up(x * x, 30);
    p  = recip_odd_fact[N_TERMS - 1];
    for (int k = N_TERMS - 2; k >= 0; k--) begin
      p = recip_odd_fact[k] - round_half_up(x2 * p, 30);
    end
    y = round_half_up(x * p, 30);
    if (y > UNIT_Q30) begin
      y = UNIT_Q30;
    end
    if (y < -UNIT_Q30) begin
      y = -UNIT_Q30;
    end
    return y[31:0];
  endfunction

  task automatic report_mismatch(input string what);
    if (mismatches < 30) begin
      $display("mismatch @%0t: %s", $realtime, what);
    end
    mismatches++;
  endtask

  always @(posedge clk) begin
    logic signed [31:0] want;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (expected_sines.size() == 0) begin
          report_mismatch($sformatf("sine word %0d with nothing pending", out_sine));
        end else begin
          want = expected_sines.pop_front();
          if (out_sine !== want) begin
            report_mismatch($sformatf("sine got %0d want %0d", out_sine, want));
          end
        end
      end
      if (in_valid && !in_stall) begin
        expected_sines.push_back(sine_of_angle(in_angle));
      end
      sines_due = expected_sines.size();
    end
  end

endmodule

FILE: tb/sv/sine_taylor_range_reduced_top_tb.sv
`timescale 1ns / 1ps

module sine_taylor_range_reduced_top_tb;
  import sintay_pkg::*;

  localparam int QTR_Q824 = 26353589;   // pi/2 in Q8.24

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_stall;
  logic signed [31:0] in_angle;
  logic               out_valid;
  logic               out_stall;
  logic signed [31:0] out_sine;

  int fail_count;
  int backlog;
  int idle_pct;
  int stall_pct;
  bit hold_req;
  bit hold_done;

  sine_taylor_range_reduced_top dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_angle  (in_angle),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_sine  (out_sine)
  );

  sine_taylor_range_reduced_checker sine_check (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_angle   (in_angle),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_sine   (out_sine),
    .fail_count (fail_count),
    .backlog    (backlog)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #1_000_000;
    $display("FAIL sine_taylor_range_reduced_top");
    $finish;
  end

  // receiver: random stall, or a long hold-off on request
  initial begin
    out_stall = 1'b0;
    hold_done = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req && !hold_done) begin
        hold_done = 1'b1;
        for (int i = 0; i < 60; i++) begin
          out_stall <= 1'b1;
          @(posedge clk);
        end
      end
      out_stall <= (stall_pct > 0) && ($urandom_range(99) < stall_pct);
    end
  end

  function automatic logic signed [31:0] random_angle();
    int     pick;
    longint k;
    pick = $urandom_range(9);
    if (pick < 4) begin
      return $urandom();
    end else if (pick < 6) begin
      // close to a quadrant boundary
      k = longint'(int'($urandom_range(162)) - 81);
      return 32'(k * QTR_Q824 + longint'(int'($urandom_range(64)) - 32));
    end else if (pick < 8) begin
      return int'($urandom_range(131072)) - 65536;
    end else begin
      return int'($urandom_range(210828714)) - 105414357;
    end
  endfunction

  task automatic send_word(input logic signed [31:0] a);
    while (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_angle <= a;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic drain_pipeline();
    in_valid <= 1'b0;
    @(negedge clk);
    while (backlog != 0) @(negedge clk);
    @(posedge clk);
  endtask

  initial begin
    logic signed [31:0] corner_angles [$];
    int idle_by_phase  [4];
    int stall_by_phase [4];
    corner_angles = '{32'sd0, 32'sd1, -32'sd1, 32'sh7FFF_FFFF, 32'sh8000_0000,
                      32'sd26353589, -32'sd26353589, 32'sd26353588, 32'sd26353590,
                      32'sd52707179, -32'sd52707179, 32'sd79060768, -32'sd79060768,
                      32'sd105414357, -32'sd105414357, 32'sd16777216, 32'sd8,
                      32'sh5555_5555, 32'shAAAA_AAAA, 32'sh00FF_FFFF, 32'shFF00_0000};
    idle_by_phase  = '{0, 61, 0, 11};
    stall_by_phase = '{0, 0, 61, 11};
    rst_n     = 1'b0;
    in_valid  = 1'b0;
    in_angle  = '0;
    idle_pct  = 0;
    stall_pct = 0;
    hold_req  = 1'b0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (corner_angles[i]) begin
      send_word(corner_angles[i]);
    end
    drain_pipeline();

    for (int ph = 0; ph < 4; ph++) begin
      idle_pct  = idle_by_phase[ph];
      stall_pct = stall_by_phase[ph];
      repeat (300) send_word(random_angle());
      drain_pipeline();
    end

    // back-to-back words against a long output hold-off fill the pipe
    idle_pct  = 0;
    stall_pct = 0;
    hold_req  = 1'b1;
    repeat (120) send_word(random_angle());
    drain_pipeline();
    repeat (30) @(negedge clk);

    if (fail_count == 0 && backlog == 0) begin
      $display("PASS sine_taylor_range_reduced_top");
    end else begin
      $display("FAIL sine_taylor_range_reduced_top");
    end
    $finish;
  end

endmodule
